FILE: design/lbc_pkg.sv
// Shared types and constants for the luma band centroid block.
// Used by lbc_front, lbc_queue, lbc_back and luma_band_centroid; depends on nothing.
package lbc_pkg;

  // Field widths
  localparam int LUMA_W     = 8;
  localparam int PIX_W      = 10;
  localparam int END_W      = 11;
  localparam int CNT_W      = 21;
  localparam int SUM_W      = 30;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  // Frame limits and count cap
  localparam logic [12:0] FRAME_WIDTH_MAX  = 13'd1024;
  localparam logic [12:0] FRAME_HEIGHT_MAX = 13'd1024;
  localparam logic [CNT_W-1:0] COUNT_CAP   = 21'd1048576;

  // Register reset values
  localparam logic [PIX_W-1:0]  WIN_FIRST_RESET = 10'd0;
  localparam logic [END_W-1:0]  WIN_END_RESET   = 11'd1024;
  localparam logic [LUMA_W-1:0] BRIGHT_RESET    = 8'd150;
  localparam logic [LUMA_W-1:0] GLARE_RESET     = 8'd220;
  localparam logic [CNT_W-1:0]  MIN_COUNT_RESET = 21'd1024;

  // Bounding box reset values
  localparam logic [PIX_W-1:0] BOX_LOW_RESET  = '1;
  localparam logic [PIX_W-1:0] BOX_HIGH_RESET = '0;

  // Divider: one quotient bit per cycle over the full sum width
  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FEW  = 2'd1,
    STATUS_FLAT = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_FIRST   = 3'd0,
    REG_X_END     = 3'd1,
    REG_Y_FIRST   = 3'd2,
    REG_Y_END     = 3'd3,
    REG_BRIGHT    = 3'd4,
    REG_GLARE     = 3'd5,
    REG_MIN_COUNT = 3'd6
  } cfg_index_e;

  typedef struct packed {
    logic [PIX_W-1:0]  x_first;
    logic [END_W-1:0]  x_end;
    logic [PIX_W-1:0]  y_first;
    logic [END_W-1:0]  y_end;
    logic [LUMA_W-1:0] bright;
    logic [LUMA_W-1:0] glare;
    logic [CNT_W-1:0]  min_count;
  } cfg_t;

  // Per-frame summary handed from the front to the back
  typedef struct packed {
    status_e          status;
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
  } frame_sum_t;

endpackage

FILE: design/lbc_front.sv
// Pixel front end: window and luma band test, frame accumulators, bounding box.
// Pushes one frame summary per end-of-frame pixel. Depends on lbc_pkg.
module lbc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lbc_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lbc_pkg::LUMA_W-1:0]    luma_i,
  input  logic [lbc_pkg::PIX_W-1:0]     pixel_x_i,
  input  logic [lbc_pkg::PIX_W-1:0]     pixel_y_i,
  input  logic                          end_of_frame_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output lbc_pkg::frame_sum_t           q_data_o
);

  logic [lbc_pkg::CNT_W-1:0] count_q, count_d;
  logic [lbc_pkg::SUM_W-1:0] sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [lbc_pkg::PIX_W-1:0] box_xl_q, box_xl_d, box_yl_q, box_yl_d;
  logic [lbc_pkg::PIX_W-1:0] box_xh_q, box_xh_d, box_yh_q, box_yh_d;
  logic                      accept;
  logic                      x_ok, y_ok, luma_ok, counted;

  // Hold the end-of-frame pixel while the summary queue is full
  assign in_stall_o = q_full_i & end_of_frame_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // Classify the pixel
  assign x_ok = (pixel_x_i >= cfg_i.x_first) &&
                ({1'b0, pixel_x_i} < cfg_i.x_end) &&
                ({3'b000, pixel_x_i} < lbc_pkg::FRAME_WIDTH_MAX);
  assign y_ok = (pixel_y_i >= cfg_i.y_first) &&
                ({1'b0, pixel_y_i} < cfg_i.y_end) &&
                ({3'b000, pixel_y_i} < lbc_pkg::FRAME_HEIGHT_MAX);
  assign luma_ok = (luma_i >= cfg_i.bright) && (luma_i <= cfg_i.glare);
  assign counted = x_ok && y_ok && luma_ok && (count_q < lbc_pkg::COUNT_CAP);

  // Accumulate counted pixels
  always_comb begin
    count_d  = count_q;
    sum_x_d  = sum_x_q;
    sum_y_d  = sum_y_q;
    box_xl_d = box_xl_q;
    box_yl_d = box_yl_q;
    box_xh_d = box_xh_q;
    box_yh_d = box_yh_q;
    if (counted) begin
      count_d = count_q + 1'b1;
      sum_x_d = sum_x_q + {{(lbc_pkg::SUM_W-lbc_pkg::PIX_W){1'b0}}, pixel_x_i};
      sum_y_d = sum_y_q + {{(lbc_pkg::SUM_W-lbc_pkg::PIX_W){1'b0}}, pixel_y_i};
      if (pixel_x_i < box_xl_q) box_xl_d = pixel_x_i;
      if (pixel_y_i < box_yl_q) box_yl_d = pixel_y_i;
      if (pixel_x_i > box_xh_q) box_xh_d = pixel_x_i;
      if (pixel_y_i > box_yh_q) box_yh_d = pixel_y_i;
    end
  end

  // Build the frame summary from the updated totals
  always_comb begin
    q_data_o.count = count_d;
    q_data_o.sum_x = sum_x_d;
    q_data_o.sum_y = sum_y_d;
    if (count_d < cfg_i.min_count) begin
      q_data_o.status = lbc_pkg::STATUS_FEW;
    end else if ((box_xh_d <= box_xl_d) || (box_yh_d <= box_yl_d)) begin
      q_data_o.status = lbc_pkg::STATUS_FLAT;
    end else begin
      q_data_o.status = lbc_pkg::STATUS_OK;
    end
  end

  assign q_push_o = accept & end_of_frame_i;

  // Advance accumulators; clear them after the last pixel of a frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      box_xl_q <= lbc_pkg::BOX_LOW_RESET;
      box_yl_q <= lbc_pkg::BOX_LOW_RESET;
      box_xh_q <= lbc_pkg::BOX_HIGH_RESET;
      box_yh_q <= lbc_pkg::BOX_HIGH_RESET;
    end else if (accept) begin
      if (end_of_frame_i) begin
        count_q  <= '0;
        sum_x_q  <= '0;
        sum_y_q  <= '0;
        box_xl_q <= lbc_pkg::BOX_LOW_RESET;
        box_yl_q <= lbc_pkg::BOX_LOW_RESET;
        box_xh_q <= lbc_pkg::BOX_HIGH_RESET;
        box_yh_q <= lbc_pkg::BOX_HIGH_RESET;
      end else begin
        count_q  <= count_d;
        sum_x_q  <= sum_x_d;
        sum_y_q  <= sum_y_d;
        box_xl_q <= box_xl_d;
        box_yl_q <= box_yl_d;
        box_xh_q <= box_xh_d;
        box_yh_q <= box_yh_d;
      end
    end
  end

endmodule

FILE: design/lbc_queue.sv
// Two-entry queue of frame summaries between the front end and the divider.
// Depends on lbc_pkg.
module lbc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lbc_pkg::frame_sum_t data_i,
  input  logic                pop_i,
  output lbc_pkg::frame_sum_t data_o,
  output logic                full_o,
  output logic                empty_o
);

  lbc_pkg::frame_sum_t mem_q [2];
  logic                wr_ptr_q, rd_ptr_q;
  logic [1:0]          fill_q;

  assign full_o  = fill_q[1];
  assign empty_o = (fill_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

FILE: design/lbc_back.sv
// Back end: radix-2 restoring divider for both centroid axes and the result register.
// Depends on lbc_pkg.
module lbc_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_empty_i,
  input  lbc_pkg::frame_sum_t        q_data_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [lbc_pkg::PIX_W-1:0]  centroid_x_o,
  output logic [lbc_pkg::PIX_W-1:0]  centroid_y_o,
  output logic [lbc_pkg::CNT_W-1:0]  pixel_count_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e                      state_q, state_d;
  logic [lbc_pkg::STEP_W-1:0]  step_q;
  lbc_pkg::status_e            status_q;
  logic [lbc_pkg::CNT_W-1:0]   count_q;
  logic [lbc_pkg::CNT_W-1:0]   rem_x_q, rem_y_q, rem_x_d, rem_y_d;
  logic [lbc_pkg::SUM_W-1:0]   quo_x_q, quo_y_q, quo_x_d, quo_y_d;
  logic                        out_free, out_load;
  logic                        out_valid_q;
  lbc_pkg::status_e            out_status_q;
  logic [lbc_pkg::PIX_W-1:0]   out_cx_q, out_cy_q;
  logic [lbc_pkg::CNT_W-1:0]   out_count_q;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  function automatic logic [lbc_pkg::CNT_W+lbc_pkg::SUM_W-1:0] div_step(
    input logic [lbc_pkg::CNT_W-1:0] rem,
    input logic [lbc_pkg::SUM_W-1:0] quo,
    input logic [lbc_pkg::CNT_W-1:0] divisor
  );
    logic [lbc_pkg::CNT_W:0] shifted;
    logic [lbc_pkg::CNT_W:0] diff;
    logic [lbc_pkg::CNT_W-1:0] rem_n;
    logic [lbc_pkg::SUM_W-1:0] quo_n;
    shifted = {rem, quo[lbc_pkg::SUM_W-1]};
    diff    = shifted - {1'b0, divisor};
    if (shifted >= {1'b0, divisor}) begin
      rem_n = diff[lbc_pkg::CNT_W-1:0];
      quo_n = {quo[lbc_pkg::SUM_W-2:0], 1'b1};
    end else begin
      rem_n = shifted[lbc_pkg::CNT_W-1:0];
      quo_n = {quo[lbc_pkg::SUM_W-2:0], 1'b0};
    end
    return {rem_n, quo_n};
  endfunction

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign q_pop_o  = (state_q == ST_IDLE) & ~q_empty_i;
  assign out_load = (state_q == ST_DONE) & out_free;

  always_comb begin
    {rem_x_d, quo_x_d} = div_step(rem_x_q, quo_x_q, count_q);
    {rem_y_d, quo_y_d} = div_step(rem_y_q, quo_y_q, count_q);
  end

  // Sequence: fetch a summary, divide if a centroid is due, then hand off
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          state_d = (q_data_i.status == lbc_pkg::STATUS_OK) ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (step_q == lbc_pkg::STEP_W'(lbc_pkg::DIV_STEPS - 1)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Divider datapath
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      status_q <= q_data_i.status;
      count_q  <= q_data_i.count;
      step_q   <= '0;
      rem_x_q  <= '0;
      rem_y_q  <= '0;
      if (q_data_i.status == lbc_pkg::STATUS_OK) begin
        quo_x_q <= q_data_i.sum_x;
        quo_y_q <= q_data_i.sum_y;
      end else begin
        quo_x_q <= '0;
        quo_y_q <= '0;
      end
    end else if (state_q == ST_DIV) begin
      step_q  <= step_q + 1'b1;
      rem_x_q <= rem_x_d;
      rem_y_q <= rem_y_d;
      quo_x_q <= quo_x_d;
      quo_y_q <= quo_y_d;
    end
  end

  // Result register: load a finished frame, drop it once transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= status_q;
      out_cx_q     <= quo_x_q[lbc_pkg::PIX_W-1:0];
      out_cy_q     <= quo_y_q[lbc_pkg::PIX_W-1:0];
      out_count_q  <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign centroid_x_o  = out_cx_q;
  assign centroid_y_o  = out_cy_q;
  assign pixel_count_o = out_count_q;

endmodule

FILE: design/luma_band_centroid.sv
// Luma band centroid, top level: configuration registers and the three stages.
// Depends on lbc_pkg, lbc_front, lbc_queue and lbc_back.
//
// Pixels are taken one per clock cycle, each with its column, row and an
// end-of-frame mark; pixels inside the window whose luma lies in
// [bright_level, glare_level] are counted, summed and boxed. The
// end-of-frame pixel closes the frame and queues its summary; that pixel is
// stalled only while two frame summaries are already waiting. Each frame
// result then passes a fetch, a 30-step radix-2 divider (one quotient bit
// per cycle, both axes in parallel) and a hand-off; frames with a failing
// status skip the divider. Results leave through an output register, so the
// divider starts the next frame while a result waits to be taken. The user
// writes configuration through a plain write port, index per register, only
// while the block is idle; the block itself does not enforce this.
module luma_band_centroid (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lbc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lbc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [lbc_pkg::LUMA_W-1:0]       luma_i,
  input  logic [lbc_pkg::PIX_W-1:0]        pixel_x_i,
  input  logic [lbc_pkg::PIX_W-1:0]        pixel_y_i,
  input  logic                             end_of_frame_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic [lbc_pkg::PIX_W-1:0]        centroid_x_o,
  output logic [lbc_pkg::PIX_W-1:0]        centroid_y_o,
  output logic [lbc_pkg::CNT_W-1:0]        pixel_count_o
);

  lbc_pkg::cfg_t       cfg_q;
  logic                q_push, q_pop, q_full, q_empty;
  lbc_pkg::frame_sum_t q_wdata, q_rdata;

  // Decode configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_first   <= lbc_pkg::WIN_FIRST_RESET;
      cfg_q.x_end     <= lbc_pkg::WIN_END_RESET;
      cfg_q.y_first   <= lbc_pkg::WIN_FIRST_RESET;
      cfg_q.y_end     <= lbc_pkg::WIN_END_RESET;
      cfg_q.bright    <= lbc_pkg::BRIGHT_RESET;
      cfg_q.glare     <= lbc_pkg::GLARE_RESET;
      cfg_q.min_count <= lbc_pkg::MIN_COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lbc_pkg::REG_X_FIRST:   cfg_q.x_first   <= cfg_data_i[lbc_pkg::PIX_W-1:0];
        lbc_pkg::REG_X_END:     cfg_q.x_end     <= cfg_data_i[lbc_pkg::END_W-1:0];
        lbc_pkg::REG_Y_FIRST:   cfg_q.y_first   <= cfg_data_i[lbc_pkg::PIX_W-1:0];
        lbc_pkg::REG_Y_END:     cfg_q.y_end     <= cfg_data_i[lbc_pkg::END_W-1:0];
        lbc_pkg::REG_BRIGHT:    cfg_q.bright    <= cfg_data_i[lbc_pkg::LUMA_W-1:0];
        lbc_pkg::REG_GLARE:     cfg_q.glare     <= cfg_data_i[lbc_pkg::LUMA_W-1:0];
        lbc_pkg::REG_MIN_COUNT: cfg_q.min_count <= cfg_data_i[lbc_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  lbc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .luma_i         (luma_i),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .end_of_frame_i (end_of_frame_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_data_o       (q_wdata)
  );

  lbc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  lbc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_data_i      (q_rdata),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .centroid_x_o  (centroid_x_o),
    .centroid_y_o  (centroid_y_o),
    .pixel_count_o (pixel_count_o)
  );

endmodule

FILE: test/luma_band_centroid_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for luma_band_centroid: directed and random pixel frames,
// each frame result predicted in-bench and compared field by field.
// Depends on lbc_pkg and the luma_band_centroid design sources.
module luma_band_centroid_test;

  localparam int CYCLE_LIMIT   = 400_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_PERCENT  = 33;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 165;

  typedef struct packed {
    logic [lbc_pkg::LUMA_W-1:0] luma;
    logic [lbc_pkg::PIX_W-1:0]  x;
    logic [lbc_pkg::PIX_W-1:0]  y;
    logic                       eof;
  } pixel_t;

  typedef struct packed {
    lbc_pkg::status_e          status;
    logic [lbc_pkg::PIX_W-1:0] cx;
    logic [lbc_pkg::PIX_W-1:0] cy;
    logic [lbc_pkg::CNT_W-1:0] count;
  } centroid_t;

  logic                           clk_i          = 1'b0;
  logic                           rst_ni         = 1'b0;
  logic                           cfg_we_i       = 1'b0;
  logic [lbc_pkg::CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [lbc_pkg::CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                           in_valid_i     = 1'b0;
  logic                           in_stall_o;
  logic [lbc_pkg::LUMA_W-1:0]     luma_i         = '0;
  logic [lbc_pkg::PIX_W-1:0]      pixel_x_i      = '0;
  logic [lbc_pkg::PIX_W-1:0]      pixel_y_i      = '0;
  logic                           end_of_frame_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i    = 1'b0;
  logic [1:0]                     status_o;
  logic [lbc_pkg::PIX_W-1:0]      centroid_x_o;
  logic [lbc_pkg::PIX_W-1:0]      centroid_y_o;
  logic [lbc_pkg::CNT_W-1:0]      pixel_count_o;

  luma_band_centroid dut (.*);

  // Pending pixels, expected frame results and the shadow of the block state
  pixel_t                    pixel_queue[$];
  centroid_t                 centroid_expected[$];
  lbc_pkg::cfg_t             reg_shadow;
  logic [lbc_pkg::CNT_W-1:0] acc_count;
  logic [lbc_pkg::SUM_W-1:0] acc_sum_x;
  logic [lbc_pkg::SUM_W-1:0] acc_sum_y;
  logic [lbc_pkg::PIX_W-1:0] box_x_lo;
  logic [lbc_pkg::PIX_W-1:0] box_y_lo;
  logic [lbc_pkg::PIX_W-1:0] box_x_hi;
  logic [lbc_pkg::PIX_W-1:0] box_y_hi;
  pixel_t                    next_pixel;
  centroid_t                 want_result;
  bit                        quiet = 1'b0;
  bit                        failed = 1'b0;
  int unsigned               cycle_count = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic clear_frame();
    acc_count = '0;
    acc_sum_x = '0;
    acc_sum_y = '0;
    box_x_lo  = lbc_pkg::BOX_LOW_RESET;
    box_y_lo  = lbc_pkg::BOX_LOW_RESET;
    box_x_hi  = lbc_pkg::BOX_HIGH_RESET;
    box_y_hi  = lbc_pkg::BOX_HIGH_RESET;
  endtask

  // Fold one accepted pixel into the frame state; queue the result on end of frame
  task automatic accumulate_pixel(input pixel_t p);
    logic                      in_window;
    logic                      in_band;
    logic [lbc_pkg::SUM_W-1:0] mean_x;
    logic [lbc_pkg::SUM_W-1:0] mean_y;
    centroid_t                 res;
    in_window = p.x >= reg_shadow.x_first && {1'b0, p.x} < reg_shadow.x_end &&
                {3'b000, p.x} < lbc_pkg::FRAME_WIDTH_MAX &&
                p.y >= reg_shadow.y_first && {1'b0, p.y} < reg_shadow.y_end &&
                {3'b000, p.y} < lbc_pkg::FRAME_HEIGHT_MAX;
    in_band = p.luma >= reg_shadow.bright && p.luma <= reg_shadow.glare;
    if (in_window && in_band && acc_count < lbc_pkg::COUNT_CAP) begin
      acc_count = acc_count + 1'b1;
      acc_sum_x = acc_sum_x + lbc_pkg::SUM_W'(p.x);
      acc_sum_y = acc_sum_y + lbc_pkg::SUM_W'(p.y);
      if (p.x < box_x_lo) box_x_lo = p.x;
      if (p.y < box_y_lo) box_y_lo = p.y;
      if (p.x > box_x_hi) box_x_hi = p.x;
      if (p.y > box_y_hi) box_y_hi = p.y;
    end
    if (p.eof) begin
      res.count = acc_count;
      res.cx    = '0;
      res.cy    = '0;
      if (acc_count < reg_shadow.min_count) begin
        res.status = lbc_pkg::STATUS_FEW;
      end else if (box_x_hi <= box_x_lo || box_y_hi <= box_y_lo) begin
        res.status = lbc_pkg::STATUS_FLAT;
      end else begin
        res.status = lbc_pkg::STATUS_OK;
        if (acc_count != 0) begin
          mean_x = acc_sum_x / lbc_pkg::SUM_W'(acc_count);
          mean_y = acc_sum_y / lbc_pkg::SUM_W'(acc_count);
          res.cx = mean_x[lbc_pkg::PIX_W-1:0];
          res.cy = mean_y[lbc_pkg::PIX_W-1:0];
        end
      end
      centroid_expected.push_back(res);
      clear_frame();
    end
  endtask

  function automatic void check_field(input string name,
                                      input logic [lbc_pkg::CNT_W-1:0] want,
                                      input logic [lbc_pkg::CNT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Write one register; the shadow follows at the same point
  task automatic write_reg(input lbc_pkg::cfg_index_e idx,
                           input logic [lbc_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      lbc_pkg::REG_X_FIRST:   reg_shadow.x_first   = value[lbc_pkg::PIX_W-1:0];
      lbc_pkg::REG_X_END:     reg_shadow.x_end     = value[lbc_pkg::END_W-1:0];
      lbc_pkg::REG_Y_FIRST:   reg_shadow.y_first   = value[lbc_pkg::PIX_W-1:0];
      lbc_pkg::REG_Y_END:     reg_shadow.y_end     = value[lbc_pkg::END_W-1:0];
      lbc_pkg::REG_BRIGHT:    reg_shadow.bright    = value[lbc_pkg::LUMA_W-1:0];
      lbc_pkg::REG_GLARE:     reg_shadow.glare     = value[lbc_pkg::LUMA_W-1:0];
      lbc_pkg::REG_MIN_COUNT: reg_shadow.min_count = value[lbc_pkg::CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input int xf, xe, yf, ye, br, gl, mc);
    write_reg(lbc_pkg::REG_X_FIRST, lbc_pkg::CFG_DATA_W'(xf));
    write_reg(lbc_pkg::REG_X_END, lbc_pkg::CFG_DATA_W'(xe));
    write_reg(lbc_pkg::REG_Y_FIRST, lbc_pkg::CFG_DATA_W'(yf));
    write_reg(lbc_pkg::REG_Y_END, lbc_pkg::CFG_DATA_W'(ye));
    write_reg(lbc_pkg::REG_BRIGHT, lbc_pkg::CFG_DATA_W'(br));
    write_reg(lbc_pkg::REG_GLARE, lbc_pkg::CFG_DATA_W'(gl));
    write_reg(lbc_pkg::REG_MIN_COUNT, lbc_pkg::CFG_DATA_W'(mc));
  endtask

  task automatic add_pixel(input int luma, input int x, input int y, input bit eof);
    pixel_t p;
    p.luma = lbc_pkg::LUMA_W'(luma);
    p.x    = lbc_pkg::PIX_W'(x);
    p.y    = lbc_pkg::PIX_W'(y);
    p.eof  = eof;
    pixel_queue.push_back(p);
  endtask

  // Hold the sender until every transfer is done and every result is in, then settle
  task automatic finish_phase();
    while (pixel_queue.size() != 0 || in_valid_i || centroid_expected.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Bias pixels into the window and the luma band so frames reach a centroid
  function automatic pixel_t random_pixel(input bit eof);
    pixel_t     p;
    logic [10:0] x_top;
    logic [10:0] y_top;
    p.luma = lbc_pkg::LUMA_W'($urandom_range(255));
    p.x    = lbc_pkg::PIX_W'($urandom_range(1023));
    p.y    = lbc_pkg::PIX_W'($urandom_range(1023));
    p.eof  = eof;
    x_top  = (reg_shadow.x_end > 11'd1024) ? 11'd1024 : reg_shadow.x_end;
    y_top  = (reg_shadow.y_end > 11'd1024) ? 11'd1024 : reg_shadow.y_end;
    if (reg_shadow.bright <= reg_shadow.glare && $urandom_range(99) < 75)
      p.luma = lbc_pkg::LUMA_W'($urandom_range(reg_shadow.glare, reg_shadow.bright));
    if ({1'b0, reg_shadow.x_first} < x_top && $urandom_range(99) < 80)
      p.x = lbc_pkg::PIX_W'($urandom_range(x_top - 1'b1, reg_shadow.x_first));
    if ({1'b0, reg_shadow.y_first} < y_top && $urandom_range(99) < 80)
      p.y = lbc_pkg::PIX_W'($urandom_range(y_top - 1'b1, reg_shadow.y_first));
    return p;
  endfunction

  task automatic push_random_frames(input int items);
    int left;
    int len;
    left = items;
    while (left > 0) begin
      len = ($urandom_range(99) < 10) ? $urandom_range(120, 40) : $urandom_range(30, 1);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) pixel_queue.push_back(random_pixel(i == len - 1));
      left -= len;
    end
  endtask

  task automatic apply_random_config(input int mode);
    int xf;
    int xe;
    int yf;
    int ye;
    int br;
    int gl;
    int mc;
    case (mode)
      0: begin
        // Widest window and band
        write_all(0, 1024, 0, 1024, 0, 255, 1);
      end
      1: begin
        xf = $urandom_range(1023);
        xe = xf + $urandom_range(300, 2);
        if (xe > 2047) xe = 2047;
        yf = $urandom_range(1023);
        ye = yf + $urandom_range(300, 2);
        if (ye > 2047) ye = 2047;
        br = $urandom_range(200);
        gl = br + $urandom_range(55);
        mc = $urandom_range(12);
        write_all(xf, xe, yf, ye, br, gl, mc);
      end
      2: begin
        // Top corner and top luma only: box never gets a width
        write_all(1023, 2047, 1023, 1024, 255, 255, 1);
      end
      default: begin
        xf = $urandom_range(1023);
        xe = $urandom_range(2047);
        yf = $urandom_range(1023);
        ye = $urandom_range(2047);
        br = $urandom_range(255);
        gl = $urandom_range(255);
        mc = ($urandom_range(1) != 0) ? $urandom_range(16) : $urandom_range(2097151);
        write_all(xf, xe, yf, ye, br, gl, mc);
      end
    endcase
  endtask

  // Driver: predict on each accepted transfer, then offer the next pixel or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o)
        accumulate_pixel({luma_i, pixel_x_i, pixel_y_i, end_of_frame_i});
      if (!in_valid_i || !in_stall_o) begin
        if (pixel_queue.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PERCENT)) begin
          next_pixel = pixel_queue.pop_front();
          in_valid_i     <= 1'b1;
          luma_i         <= next_pixel.luma;
          pixel_x_i      <= next_pixel.x;
          pixel_y_i      <= next_pixel.y;
          end_of_frame_i <= next_pixel.eof;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expectation, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (centroid_expected.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d count %0d",
                   $time, status_o, pixel_count_o);
          failed = 1'b1;
        end else begin
          want_result = centroid_expected.pop_front();
          check_field("status", lbc_pkg::CNT_W'(want_result.status),
                      lbc_pkg::CNT_W'(status_o));
          check_field("centroid_x", lbc_pkg::CNT_W'(want_result.cx),
                      lbc_pkg::CNT_W'(centroid_x_o));
          check_field("centroid_y", lbc_pkg::CNT_W'(want_result.cy),
                      lbc_pkg::CNT_W'(centroid_y_o));
          check_field("pixel_count", want_result.count, pixel_count_o);
        end
      end
      out_stall_i <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    reg_shadow = '{x_first: lbc_pkg::WIN_FIRST_RESET, x_end: lbc_pkg::WIN_END_RESET,
                   y_first: lbc_pkg::WIN_FIRST_RESET, y_end: lbc_pkg::WIN_END_RESET,
                   bright: lbc_pkg::BRIGHT_RESET, glare: lbc_pkg::GLARE_RESET,
                   min_count: lbc_pkg::MIN_COUNT_RESET};
    clear_frame();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: luma band edges, frame corners, too few pixels
    add_pixel(0, 0, 0, 0);
    add_pixel(149, 5, 5, 0);
    add_pixel(150, 0, 0, 0);
    add_pixel(220, 1023, 1023, 0);
    add_pixel(221, 7, 7, 0);
    add_pixel(255, 1023, 0, 1);
    finish_phase();

    // Zero minimum count: empty frame, full-span centroid, box with no width
    write_all(0, 1024, 0, 1024, 150, 220, 0);
    add_pixel(0, 3, 3, 1);
    add_pixel(150, 0, 0, 0);
    add_pixel(220, 1023, 1023, 1);
    add_pixel(200, 40, 10, 0);
    add_pixel(200, 40, 900, 1);
    finish_phase();

    // Empty column window and inverted row window
    write_all(600, 600, 900, 100, 0, 255, 1);
    add_pixel(128, 600, 500, 0);
    add_pixel(128, 599, 99, 0);
    add_pixel(128, 700, 950, 1);
    finish_phase();

    // Bright level above glare level
    write_all(0, 1024, 0, 1024, 200, 100, 1);
    add_pixel(150, 10, 10, 0);
    add_pixel(100, 20, 20, 0);
    add_pixel(200, 30, 30, 1);
    finish_phase();

    // Window edges: first bound in, end bound out
    write_all(100, 103, 200, 202, 0, 255, 2);
    add_pixel(0, 100, 200, 0);
    add_pixel(255, 102, 201, 0);
    add_pixel(9, 103, 201, 0);
    add_pixel(9, 99, 200, 0);
    add_pixel(9, 101, 202, 1);
    finish_phase();

    // Random frames under a fresh setting per phase
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      apply_random_config(phase % 4);
      quiet = (phase == 5);
      push_random_frames(PHASE_ITEMS);
      finish_phase();
    end
    quiet = 1'b0;

    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: luma_band_centroid.f
design/lbc_pkg.sv
design/lbc_front.sv
design/lbc_queue.sv
design/lbc_back.sv
design/luma_band_centroid.sv
test/luma_band_centroid_test.sv
